[design/ewsd_pkg.sv]
// Shared types and constants for the event word stream deframer.
`timescale 1ns / 1ps
`default_nettype none

package ewsd_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned LengthWidth = 16;

  // Bit positions of the length fields inside their header words
  localparam int unsigned ModCountLsb = 52;
  localparam int unsigned SampleCountLsb = 27;

  // Fixed number of digitizers in every module
  localparam logic [2:0] DIGITIZERS_PER_MODULE = 3'd5;
  // Channel trailer is three words: sub-word index of the last one
  localparam logic [1:0] ChTrlLastSub = 2'd2;
  localparam logic [2:0] LanesPerWord = 3'd4;

  // Framing phase; the code doubles as the word kind reported downstream
  typedef enum logic [3:0] {
    PH_EVT_HDR  = 4'd0,
    PH_PAY_HDR  = 4'd1,
    PH_MOD_DESC = 4'd2,
    PH_MOD_HDR1 = 4'd3,
    PH_MOD_HDR2 = 4'd4,
    PH_CH_HDR1  = 4'd5,
    PH_CH_HDR2  = 4'd6,
    PH_WF_HDR1  = 4'd7,
    PH_WF_HDR2  = 4'd8,
    PH_DATA     = 4'd9,
    PH_CH_TRL   = 4'd10,
    PH_MOD_TRL  = 4'd13,
    PH_PAY_TRL  = 4'd14,
    PH_EVT_TRL  = 4'd15
  } phase_e;

  // One tagged word, as handed from the tracker to the output stage
  typedef struct packed {
    logic [3:0]                     word_kind;
    logic [3:0]                     module_index;
    logic [2:0]                     digitizer_index;
    logic signed [SampleWidth-1:0]  sample_zero;
    logic signed [SampleWidth-1:0]  sample_one;
    logic signed [SampleWidth-1:0]  sample_two;
    logic signed [SampleWidth-1:0]  sample_three;
    logic [2:0]                     samples_valid;
    logic [LengthWidth-1:0]         length_field;
    logic [WordWidth-1:0]           raw_word;
    logic                           end_of_event;
  } tag_t;

endpackage

`default_nettype wire

[design/event_word_stream_deframer_unit.sv]
// Top level of the event word stream deframer: tracker plus registered output with skid.
// An accepted item loads the result register, or waits in the skid register while that is stalled.
// Throughput: one item per cycle while the skid register is empty; each word needs one phase update in the tracker.
// The skid register keeps s_axis_tready registered, so a master-side stall costs no item.
// Reset (rst_ni low, asynchronous): framing restarts at the event header, counters
// clear and both output stages are emptied.
`timescale 1ns / 1ps
`default_nettype none

module event_word_stream_deframer_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input: data_word [63:0]
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,
  // Output tdata, low bit up: module_index [3:0], digitizer_index [6:4],
  // sample_zero [22:7], sample_one [38:23], sample_two [54:39],
  // sample_three [70:55], samples_valid [73:71], length_field [89:74],
  // raw_word [153:90], zero fill [159:154]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [159:0]      m_axis_tdata,
  // word_kind [3:0]
  output logic [3:0]        m_axis_tuser,
  // end_of_event
  output logic              m_axis_tlast
);

  logic           in_fire;
  logic           out_free;
  ewsd_pkg::tag_t tag;

  ewsd_pkg::tag_t out_q, skid_q;
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;

  // Take a new item whenever the skid slot is empty
  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // The result register can load when it is empty or being drained
  assign out_free      = !out_valid_q || m_axis_tready;

  // Tag the word against the current framing position; advance only on accept
  ewsd_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(in_fire),
    .word_i   (s_axis_tdata),
    .tag_o    (tag)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      // Refill from skid first; an accept cannot coincide with a full skid
      out_valid_d  = skid_valid_q || in_fire;
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      // Result register is stalled: park the new item
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : tag;
    end
    if (!out_free && in_fire) begin
      skid_q <= tag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.word_kind;
  assign m_axis_tlast  = out_q.end_of_event;
  assign m_axis_tdata  = {6'd0,
                          out_q.raw_word,
                          out_q.length_field,
                          out_q.samples_valid,
                          out_q.sample_three,
                          out_q.sample_two,
                          out_q.sample_one,
                          out_q.sample_zero,
                          out_q.digitizer_index,
                          out_q.module_index};

endmodule

`default_nettype wire

[design/ewsd_tracker.sv]
// Framing position tracker: holds the phase and counters, tags the current word.
`timescale 1ns / 1ps
`default_nettype none

module ewsd_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           advance_i,
  input  wire logic [ewsd_pkg::WordWidth-1:0] word_i,
  output ewsd_pkg::tag_t                      tag_o
);

  ewsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  module_total_q, module_total_d;
  logic [3:0]  module_counter_q, module_counter_d;
  logic [2:0]  digitizer_counter_q, digitizer_counter_d;
  logic [15:0] samples_left_q, samples_left_d;
  logic [1:0]  sub_word_counter_q, sub_word_counter_d;

  logic [3:0]  mod_count;
  logic [15:0] sample_count;
  logic [2:0]  lanes;
  logic [3:0]  module_inc;
  logic [2:0]  digitizer_inc;

  assign mod_count     = word_i[ewsd_pkg::ModCountLsb +: 4];
  assign sample_count  = word_i[ewsd_pkg::SampleCountLsb +: 16];
  assign lanes         = (samples_left_q < 16'(ewsd_pkg::LanesPerWord))
                         ? samples_left_q[2:0] : ewsd_pkg::LanesPerWord;
  assign module_inc    = module_counter_q + 4'd1;
  assign digitizer_inc = digitizer_counter_q + 3'd1;

  // Next state
  always_comb begin
    phase_d             = phase_q;
    module_total_d      = module_total_q;
    module_counter_d    = module_counter_q;
    digitizer_counter_d = digitizer_counter_q;
    samples_left_d      = samples_left_q;
    sub_word_counter_d  = sub_word_counter_q;
    unique case (phase_q)
      ewsd_pkg::PH_EVT_HDR: phase_d = ewsd_pkg::PH_PAY_HDR;
      ewsd_pkg::PH_PAY_HDR: begin
        module_total_d   = mod_count;
        module_counter_d = 4'd0;
        phase_d = (mod_count == 4'd0) ? ewsd_pkg::PH_PAY_TRL : ewsd_pkg::PH_MOD_DESC;
      end
      ewsd_pkg::PH_MOD_DESC: begin
        if (module_inc == module_total_q) begin
          module_counter_d = 4'd0;
          phase_d          = ewsd_pkg::PH_MOD_HDR1;
        end else begin
          module_counter_d = module_inc;
        end
      end
      ewsd_pkg::PH_MOD_HDR1: phase_d = ewsd_pkg::PH_MOD_HDR2;
      ewsd_pkg::PH_MOD_HDR2: begin
        digitizer_counter_d = 3'd0;
        phase_d             = ewsd_pkg::PH_CH_HDR1;
      end
      ewsd_pkg::PH_CH_HDR1: phase_d = ewsd_pkg::PH_CH_HDR2;
      ewsd_pkg::PH_CH_HDR2: begin
        samples_left_d = sample_count;
        phase_d        = ewsd_pkg::PH_WF_HDR1;
      end
      ewsd_pkg::PH_WF_HDR1: phase_d = ewsd_pkg::PH_WF_HDR2;
      ewsd_pkg::PH_WF_HDR2: begin
        sub_word_counter_d = 2'd0;
        phase_d = (samples_left_q == 16'd0) ? ewsd_pkg::PH_CH_TRL : ewsd_pkg::PH_DATA;
      end
      ewsd_pkg::PH_DATA: begin
        samples_left_d = samples_left_q - 16'(lanes);
        if (samples_left_q == 16'(lanes)) begin
          sub_word_counter_d = 2'd0;
          phase_d            = ewsd_pkg::PH_CH_TRL;
        end
      end
      ewsd_pkg::PH_CH_TRL: begin
        if (sub_word_counter_q >= ewsd_pkg::ChTrlLastSub) begin
          sub_word_counter_d  = 2'd0;
          digitizer_counter_d = digitizer_inc;
          phase_d = (digitizer_inc == ewsd_pkg::DIGITIZERS_PER_MODULE)
                    ? ewsd_pkg::PH_MOD_TRL : ewsd_pkg::PH_CH_HDR1;
        end else begin
          sub_word_counter_d = sub_word_counter_q + 2'd1;
        end
      end
      ewsd_pkg::PH_MOD_TRL: begin
        module_counter_d    = module_inc;
        digitizer_counter_d = 3'd0;
        phase_d = (module_inc == module_total_q) ? ewsd_pkg::PH_PAY_TRL
                                                 : ewsd_pkg::PH_MOD_HDR1;
      end
      ewsd_pkg::PH_PAY_TRL: phase_d = ewsd_pkg::PH_EVT_TRL;
      default: begin
        // Event trailer, or an unused code: start over on a new event
        phase_d             = ewsd_pkg::PH_EVT_HDR;
        module_total_d      = 4'd0;
        module_counter_d    = 4'd0;
        digitizer_counter_d = 3'd0;
        samples_left_d      = 16'd0;
        sub_word_counter_d  = 2'd0;
      end
    endcase
  end

  // Tag of the current word
  always_comb begin
    tag_o                 = '0;
    tag_o.raw_word        = word_i;
    tag_o.word_kind       = phase_q;
    tag_o.module_index    = module_counter_q;
    tag_o.digitizer_index = digitizer_counter_q;
    unique case (phase_q)
      ewsd_pkg::PH_EVT_HDR,
      ewsd_pkg::PH_PAY_TRL: begin
        tag_o.module_index    = 4'd0;
        tag_o.digitizer_index = 3'd0;
      end
      ewsd_pkg::PH_PAY_HDR: begin
        tag_o.module_index    = 4'd0;
        tag_o.digitizer_index = 3'd0;
        tag_o.length_field    = 16'(mod_count);
      end
      ewsd_pkg::PH_MOD_DESC,
      ewsd_pkg::PH_MOD_HDR1,
      ewsd_pkg::PH_MOD_HDR2,
      ewsd_pkg::PH_MOD_TRL: tag_o.digitizer_index = 3'd0;
      ewsd_pkg::PH_CH_HDR1,
      ewsd_pkg::PH_WF_HDR1,
      ewsd_pkg::PH_WF_HDR2: ;
      ewsd_pkg::PH_CH_HDR2: tag_o.length_field = sample_count;
      ewsd_pkg::PH_DATA: begin
        tag_o.samples_valid = lanes;
        // Zero the lanes past the last valid sample
        if (lanes > 3'd0) tag_o.sample_zero  = word_i[15:0];
        if (lanes > 3'd1) tag_o.sample_one   = word_i[31:16];
        if (lanes > 3'd2) tag_o.sample_two   = word_i[47:32];
        if (lanes > 3'd3) tag_o.sample_three = word_i[63:48];
      end
      ewsd_pkg::PH_CH_TRL: tag_o.word_kind = 4'(ewsd_pkg::PH_CH_TRL) + 4'(sub_word_counter_q);
      default: begin
        tag_o.word_kind       = ewsd_pkg::PH_EVT_TRL;
        tag_o.module_index    = 4'd0;
        tag_o.digitizer_index = 3'd0;
        tag_o.end_of_event    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= ewsd_pkg::PH_EVT_HDR;
      module_total_q      <= 4'd0;
      module_counter_q    <= 4'd0;
      digitizer_counter_q <= 3'd0;
      samples_left_q      <= 16'd0;
      sub_word_counter_q  <= 2'd0;
    end else if (advance_i) begin
      phase_q             <= phase_d;
      module_total_q      <= module_total_d;
      module_counter_q    <= module_counter_d;
      digitizer_counter_q <= digitizer_counter_d;
      samples_left_q      <= samples_left_d;
      sub_word_counter_q  <= sub_word_counter_d;
    end
  end

endmodule

`default_nettype wire

[verif/event_tag_checker.sv]
// Scoreboard for the deframer: tags every accepted word and checks the tagged stream.
`timescale 1ns / 1ps

module event_tag_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [159:0] m_axis_tdata,
  input  logic [3:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o,
  output int           checked_o
);
  import ewsd_pkg::*;

  // Framing position of the next word, tracked independently of the block
  phase_e      frame_phase;
  logic [3:0]  modules_in_event;
  logic [3:0]  module_pos;
  logic [2:0]  digitizer_pos;
  logic [15:0] samples_to_go;
  logic [1:0]  trailer_pos;

  tag_t expected_tags[$];
  tag_t want;
  tag_t fresh;

  task automatic clear_framing();
    frame_phase = PH_EVT_HDR;
    modules_in_event = '0;
    module_pos = '0;
    digitizer_pos = '0;
    samples_to_go = '0;
    trailer_pos = '0;
  endtask

  // Tag one word by its position and advance the framing state
  task automatic tag_word(input logic [63:0] w, output tag_t t);
    logic [2:0] lanes;
    t = '0;
    t.word_kind = frame_phase;
    t.raw_word = w;
    if (frame_phase >= PH_MOD_DESC && frame_phase <= PH_MOD_TRL) t.module_index = module_pos;
    if (frame_phase >= PH_CH_HDR1 && frame_phase <= PH_CH_TRL) t.digitizer_index = digitizer_pos;
    case (frame_phase)
      PH_EVT_HDR: frame_phase = PH_PAY_HDR;
      PH_PAY_HDR: begin
        modules_in_event = w[ModCountLsb +: 4];
        t.length_field = {12'd0, modules_in_event};
        module_pos = '0;
        frame_phase = (modules_in_event == 4'd0) ? PH_PAY_TRL : PH_MOD_DESC;
      end
      PH_MOD_DESC: begin
        module_pos = module_pos + 4'd1;
        if (module_pos == modules_in_event) begin
          module_pos = '0;
          frame_phase = PH_MOD_HDR1;
        end
      end
      PH_MOD_HDR1: frame_phase = PH_MOD_HDR2;
      PH_MOD_HDR2: begin
        digitizer_pos = '0;
        frame_phase = PH_CH_HDR1;
      end
      PH_CH_HDR1: frame_phase = PH_CH_HDR2;
      PH_CH_HDR2: begin
        samples_to_go = w[SampleCountLsb +: LengthWidth];
        t.length_field = samples_to_go;
        frame_phase = PH_WF_HDR1;
      end
      PH_WF_HDR1: frame_phase = PH_WF_HDR2;
      PH_WF_HDR2: begin
        trailer_pos = '0;
        frame_phase = (samples_to_go == 16'd0) ? PH_CH_TRL : PH_DATA;
      end
      PH_DATA: begin
        // only the leftover samples are valid in the last word, the rest read zero
        lanes = (samples_to_go < LanesPerWord) ? samples_to_go[2:0] : LanesPerWord;
        t.samples_valid = lanes;
        if (lanes > 3'd0) t.sample_zero = w[15:0];
        if (lanes > 3'd1) t.sample_one = w[31:16];
        if (lanes > 3'd2) t.sample_two = w[47:32];
        if (lanes > 3'd3) t.sample_three = w[63:48];
        samples_to_go = samples_to_go - lanes;
        if (samples_to_go == 16'd0) begin
          trailer_pos = '0;
          frame_phase = PH_CH_TRL;
        end
      end
      PH_CH_TRL: begin
        t.word_kind = PH_CH_TRL + {2'b00, trailer_pos};
        if (trailer_pos >= ChTrlLastSub) begin
          trailer_pos = '0;
          digitizer_pos = digitizer_pos + 3'd1;
          frame_phase = (digitizer_pos == DIGITIZERS_PER_MODULE) ? PH_MOD_TRL : PH_CH_HDR1;
        end else begin
          trailer_pos = trailer_pos + 2'd1;
        end
      end
      PH_MOD_TRL: begin
        module_pos = module_pos + 4'd1;
        digitizer_pos = '0;
        frame_phase = (module_pos == modules_in_event) ? PH_PAY_TRL : PH_MOD_HDR1;
      end
      PH_PAY_TRL: frame_phase = PH_EVT_TRL;
      default: begin
        // event trailer: close the event and expect a new header next
        t.word_kind = PH_EVT_TRL;
        t.end_of_event = 1'b1;
        clear_framing();
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Retire results before tagging new words: a result never leaves in the cycle its word enters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_framing();
      expected_tags.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tags.size() == 0) begin
          $error("tagged item with nothing expected, raw %h", m_axis_tdata[153:90]);
          fail_count_o++;
        end else begin
          want = expected_tags.pop_front();
          check_field("word_kind", want.word_kind, m_axis_tuser);
          check_field("module_index", want.module_index, m_axis_tdata[3:0]);
          check_field("digitizer_index", want.digitizer_index, m_axis_tdata[6:4]);
          check_field("sample_zero", $unsigned(want.sample_zero), m_axis_tdata[22:7]);
          check_field("sample_one", $unsigned(want.sample_one), m_axis_tdata[38:23]);
          check_field("sample_two", $unsigned(want.sample_two), m_axis_tdata[54:39]);
          check_field("sample_three", $unsigned(want.sample_three), m_axis_tdata[70:55]);
          check_field("samples_valid", want.samples_valid, m_axis_tdata[73:71]);
          check_field("length_field", want.length_field, m_axis_tdata[89:74]);
          check_field("raw_word", want.raw_word, m_axis_tdata[153:90]);
          check_field("zero_fill", 64'd0, m_axis_tdata[159:154]);
          check_field("end_of_event", want.end_of_event, m_axis_tlast);
          checked_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tag_word(s_axis_tdata, fresh);
        expected_tags.push_back(fresh);
      end
      pending_o = expected_tags.size();
    end
  end

endmodule

[verif/tb_event_word_stream_deframer_unit.sv]
// Stimulus, flow control and verdict for the event word stream deframer regression.
`timescale 1ns / 1ps

module tb_event_word_stream_deframer_unit;
  import ewsd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int TargetWords   = 1850;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAfter  = 300;
  // Long channel: 251 data words, the last one holding a single sample
  localparam int LongCount     = 1001;

  // How channel sample counts are chosen within an event
  localparam int CountRandom = 0;
  localparam int CountLadder = 1;  // digitizer d carries d samples
  localparam int CountMax    = 2;  // first channel carries the long count

  // Word content outside the length fields
  localparam int FillZero   = 0;
  localparam int FillOnes   = 1;
  localparam int FillRandom = 2;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int fail_count;
  int pending;
  int checked;
  int words_sent = 0;
  int events_sent = 0;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  event_word_stream_deframer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  event_tag_checker tag_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Sender gap: mostly back to back, some short gaps, a few long ones,
  // and now and then a burst of a few hundred items with no gap at all
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) begin
      burst_left = $urandom_range(100, 300);
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Bias sample lanes toward the signed extremes
  function automatic logic [15:0] sample_lane();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] fill_word(input int fill);
    if (fill == FillZero) return '0;
    if (fill == FillOnes) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] data_word(input int fill);
    if (fill != FillRandom) return fill_word(fill);
    return {sample_lane(), sample_lane(), sample_lane(), sample_lane()};
  endfunction

  // Keep most channels short so events stay a few dozen words long
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return 0;
    if (r < 16) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  function automatic int pick_modules();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 0;
    if (r < 12) return 1;
    if (r < 18) return $urandom_range(2, 3);
    return $urandom_range(4, 15);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_word(input logic [63:0] w);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Build one well-formed event record; only the module count and the
  // sample counts steer the framing, every other bit is free content
  task automatic send_event(input int n_mod, input int count_mode, input int fill);
    logic [63:0] w;
    int cnt;
    send_word(fill_word(fill));                       // event header
    w = fill_word(fill);
    w[ModCountLsb +: 4] = n_mod[3:0];
    send_word(w);                                     // payload header
    for (int m = 0; m < n_mod; m++) send_word(fill_word(fill));
    for (int m = 0; m < n_mod; m++) begin
      send_word(fill_word(fill));
      send_word(fill_word(fill));
      for (int d = 0; d < int'(DIGITIZERS_PER_MODULE); d++) begin
        if (count_mode == CountLadder) cnt = d;
        else if (count_mode == CountMax && m == 0 && d == 0) cnt = LongCount;
        else cnt = pick_count();
        send_word(fill_word(fill));                   // channel header one
        w = fill_word(fill);
        w[SampleCountLsb +: LengthWidth] = cnt[15:0];
        send_word(w);                                 // channel header two
        send_word(fill_word(fill));
        send_word(fill_word(fill));
        for (int i = 0; i < cnt; i += 4) send_word(data_word(fill));
        repeat (3) send_word(fill_word(fill));        // channel trailer
      end
      send_word(fill_word(fill));                     // module trailer
    end
    send_word(fill_word(fill));                       // payload trailer
    send_word(fill_word(fill));                       // event trailer
    events_sent++;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty events with all-zero and all-one content, then one
    // module whose channels step through zero, partial and full data words
    send_event(0, CountRandom, FillZero);
    send_event(0, CountRandom, FillOnes);
    send_event(1, CountLadder, FillRandom);
    send_event(1, CountLadder, FillOnes);
    // Largest module count, then one long channel
    send_event(15, CountRandom, FillRandom);
    send_event(1, CountMax, FillRandom);

    while (words_sent < TargetWords)
      send_event(pick_modules(), CountRandom, FillRandom);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // Drain: wait for every tagged word, then allow for stray output
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d words in %0d events: zero to fifteen modules, empty, partial and",
             words_sent, events_sent);
    $display("full data words, a %0d-sample channel and a %0d-cycle hold-off; %0d compared.",
             LongCount, HoldOffCycles, checked);
    if (fail_count == 0) begin
      $display("event_word_stream_deframer_unit regression: pass");
    end else begin
      $display("event_word_stream_deframer_unit regression: fail");
    end
    $finish;
  end

  // Receiver: random ready runs and stalls, plus one long hold-off so the
  // output stages fill and the block pushes back on its input
  initial begin : result_sink
    int run;
    int stall;
    int r;
    bit held_off;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 19);
      run = (r < 17) ? $urandom_range(1, 8) : $urandom_range(50, 200);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!held_off && words_sent >= HoldOffAfter) begin
        held_off = 1'b1;
        stall = HoldOffCycles;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 14) stall = $urandom_range(1, 2);
        else if (r < 19) stall = $urandom_range(3, 10);
        else stall = $urandom_range(20, 60);
      end
      m_axis_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  // Abort when neither side has moved an item for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d results pending",
             WatchdogLimit, pending);
    $display("event_word_stream_deframer_unit regression: fail");
    $finish;
  end

endmodule
